/* sv/qte_pkg.sv */
// shared constants and the arctangent table for the quaternion to euler angle unit
package qte_pkg;

  // default number of cordic micro-rotations
  localparam int CORDIC_STEPS_DEF = 16;
  // angle accumulator width, radians at scale 2^16
  localparam int ZW = 20;
  // angle limits
  localparam int HALF_PI_Q13 = 12868;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q16 = 102944;
  // square root: result bits and radicand width
  localparam int SQ_BITS = 29;
  localparam int SQ_IN_W = 57;
  // datapath widths of the two arctangent flavors
  localparam int RY_W = 38;
  localparam int P_W = 32;

  // atan(2^-i) in radians at scale 2^16
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 20'sd51472;
      1: v = 20'sd30386;
      2: v = 20'sd16055;
      3: v = 20'sd8150;
      4: v = 20'sd4091;
      5: v = 20'sd2047;
      6: v = 20'sd1024;
      7: v = 20'sd512;
      8: v = 20'sd256;
      9: v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      16: v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/quaternion_to_euler_angles_unit.sv */
// quaternion to roll, pitch and yaw: top level with product stages and output skid
// One word per cycle in and out: a quaternion in signed q2.14 enters whenever in_ready is high,
// and its roll, pitch and yaw in signed q3.13 radians leave while out_ready is high; the
// delay through the unit is set by the pitch path, the longest one:
// two product/sum stages, a 14-bit split square, a 29-stage bit-per-stage square root and
// the pitch arctangent pipeline. Roll and yaw run alongside and are delayed to match.
// A two-entry output buffer keeps taking words while a result waits; in_ready falls only
// when both entries are full or in reset. Pitch saturates to +-pi/2 with pitch_clamped set when
// |2(wy - xz)| reaches one. No state is kept between words.
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_clamped
);
  import qte_pkg::*;

  localparam int LC = CORDIC_STEPS + 2;
  localparam int D_RY = 2 + SQ_BITS;
  localparam int D_CL = D_RY + LC;
  localparam int LAT = 2 + D_CL;
  localparam int SW = 36;
  localparam logic signed [SW-1:0] ONE_Q28 = SW'(1) <<< 28;

  logic en;
  logic skid_v_r;
  logic out_valid_r;
  logic v_r [LAT];

  assign en = !skid_v_r;
  assign in_ready = en && rst_n;

  // valid bits follow the words down the pipeline
  for (genvar s = 0; s < LAT; s++) begin : g_valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        if (s == 0) begin
          v_r[s] <= in_valid;
        end else begin
          v_r[s] <= v_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, xz_r, wz_r, xy_r, zz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_quat_w * in_quat_x;
      yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;
      yy_r <= in_quat_y * in_quat_y;
      wy_r <= in_quat_w * in_quat_y;
      xz_r <= in_quat_x * in_quat_z;
      wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;
    end
  end

  // stage 2: sums of products at scale 2^28
  logic signed [SW-1:0] sr_r, cr_r, sp_r, sy_r, cy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= (SW'(wx_r) + SW'(yz_r)) <<< 1;
      cr_r <= ONE_Q28 - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
      sp_r <= (SW'(wy_r) - SW'(xz_r)) <<< 1;
      sy_r <= (SW'(wz_r) + SW'(xy_r)) <<< 1;
      cy_r <= ONE_Q28 - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
    end
  end

  // roll and yaw arctangents
  logic signed [15:0] roll_c, yaw_c;
  qte_cordic #(.W(RY_W), .STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_roll (
    .clk(clk), .en(en), .y_i(RY_W'(sr_r)), .x_i(RY_W'(cr_r)), .angle_o(roll_c)
  );
  qte_cordic #(.W(RY_W), .STEPS(CORDIC_STEPS), .LIM(PI_Q13)) u_yaw (
    .clk(clk), .en(en), .y_i(RY_W'(sy_r)), .x_i(RY_W'(cy_r)), .angle_o(yaw_c)
  );

  // stage 3: split square of |sp|
  logic [SW-1:0] sp_abs;
  logic [27:0]   hh_r, hl_r, ll_r;
  assign sp_abs = sp_r[SW-1] ? SW'(-sp_r) : SW'(sp_r);
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= sp_abs[27:14] * sp_abs[27:14];
      hl_r <= sp_abs[27:14] * sp_abs[13:0];
      ll_r <= sp_abs[13:0] * sp_abs[13:0];
    end
  end

  // stage 4: radicand 2^56 - sp^2
  logic [55:0]        s2;
  logic [SQ_IN_W-1:0] c2_r;
  assign s2 = (56'(hh_r) << 28) + (56'(hl_r) << 15) + 56'(ll_r);
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= (SQ_IN_W'(1) << 56) - SQ_IN_W'(s2);
    end
  end

  logic [SQ_BITS-1:0] cp;
  qte_isqrt u_sqrt (.clk(clk), .en(en), .v_i(c2_r), .root_o(cp));

  // sp delayed to meet the root
  logic signed [SW-1:0] sp_d_r [D_RY];
  for (genvar d = 0; d < D_RY; d++) begin : g_spd
    always_ff @(posedge clk) begin
      if (en) begin
        sp_d_r[d] <= (d == 0) ? sp_r : sp_d_r[(d == 0) ? 0 : d-1];
      end
    end
  end

  logic signed [15:0] pitch_c;
  qte_cordic #(.W(P_W), .STEPS(CORDIC_STEPS), .LIM(HALF_PI_Q13)) u_pitch (
    .clk(clk), .en(en), .y_i(P_W'(sp_d_r[D_RY-1])), .x_i(P_W'(cp)), .angle_o(pitch_c)
  );

  // clamp flag and sign, delayed to meet the pitch angle
  logic cl_d_r [D_CL];
  logic sg_d_r [D_CL];
  for (genvar d = 0; d < D_CL; d++) begin : g_cld
    always_ff @(posedge clk) begin
      if (en) begin
        if (d == 0) begin
          cl_d_r[d] <= (sp_r >= ONE_Q28) || (sp_r <= -ONE_Q28);
          sg_d_r[d] <= sp_r > 0;
        end else begin
          cl_d_r[d] <= cl_d_r[(d == 0) ? 0 : d-1];
          sg_d_r[d] <= sg_d_r[(d == 0) ? 0 : d-1];
        end
      end
    end
  end

  // roll and yaw delayed to meet the pitch angle
  logic signed [15:0] roll_d_r [D_RY];
  logic signed [15:0] yaw_d_r [D_RY];
  for (genvar d = 0; d < D_RY; d++) begin : g_ryd
    always_ff @(posedge clk) begin
      if (en) begin
        if (d == 0) begin
          roll_d_r[d] <= roll_c;
          yaw_d_r[d] <= yaw_c;
        end else begin
          roll_d_r[d] <= roll_d_r[(d == 0) ? 0 : d-1];
          yaw_d_r[d] <= yaw_d_r[(d == 0) ? 0 : d-1];
        end
      end
    end
  end

  // final pitch selection
  logic signed [14:0] pitch_fin;
  always_comb begin
    if (cl_d_r[D_CL-1]) begin
      pitch_fin = sg_d_r[D_CL-1] ? 15'(HALF_PI_Q13) : -15'(HALF_PI_Q13);
    end else begin
      pitch_fin = pitch_c[14:0];
    end
  end

  // output register and skid entry
  logic               v_last;
  logic               take_new;
  logic               to_skid;
  logic               from_skid;
  logic               out_valid_nxt;
  logic               skid_v_nxt;
  logic signed [15:0] o_roll_r, o_yaw_r, k_roll_r, k_yaw_r;
  logic signed [14:0] o_pitch_r, k_pitch_r;
  logic               o_cl_r, k_cl_r;

  assign v_last = v_r[LAT-1];
  assign take_new = en && v_last && (!out_valid_r || out_ready);
  assign to_skid = en && v_last && out_valid_r && !out_ready;
  assign from_skid = !en && out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt = skid_v_r;
    if (take_new || from_skid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (to_skid) begin
      skid_v_nxt = 1'b1;
    end else if (from_skid) begin
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      o_roll_r <= roll_d_r[D_RY-1];
      o_yaw_r <= yaw_d_r[D_RY-1];
      o_pitch_r <= pitch_fin;
      o_cl_r <= cl_d_r[D_CL-1];
    end else if (from_skid) begin
      o_roll_r <= k_roll_r;
      o_yaw_r <= k_yaw_r;
      o_pitch_r <= k_pitch_r;
      o_cl_r <= k_cl_r;
    end
    if (to_skid) begin
      k_roll_r <= roll_d_r[D_RY-1];
      k_yaw_r <= yaw_d_r[D_RY-1];
      k_pitch_r <= pitch_fin;
      k_cl_r <= cl_d_r[D_CL-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_roll_angle = o_roll_r;
  assign out_pitch_angle = o_pitch_r;
  assign out_yaw_angle = o_yaw_r;
  assign out_pitch_clamped = o_cl_r;

  // a held skid word always has a word ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid word without output word");

  // a word leaving the pipeline is never dropped
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_last) |=> (out_valid_r && (skid_v_r || $past(!out_valid_r || out_ready))))
    else $error("pipeline word lost at output");

  // saturated pitch is exactly plus or minus a quarter turn
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_cl_r) |->
      (o_pitch_r == 15'(HALF_PI_Q13) || o_pitch_r == -15'(HALF_PI_Q13)))
    else $error("clamped pitch is not a quarter turn");

endmodule

/* sv/qte_isqrt.sv */
// pipelined floor square root, one result bit per stage
module qte_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qte_pkg::SQ_IN_W-1:0]  v_i,
  output logic [qte_pkg::SQ_BITS-1:0] root_o
);
  import qte_pkg::*;

  localparam int EW = SQ_IN_W + 2;

  logic [SQ_IN_W-1:0] rem_r [SQ_BITS];
  logic [SQ_BITS-1:0] res_r [SQ_BITS];

  for (genvar i = 0; i < SQ_BITS; i++) begin : g_stage
    localparam int K = SQ_BITS - 1 - i;
    logic [SQ_IN_W-1:0] rem_in;
    logic [SQ_BITS-1:0] res_in;
    logic [EW-1:0]      cand;
    logic [EW-1:0]      rem_ext;

    if (i == 0) begin : g_first
      assign rem_in = v_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
    end

    // (res + 2^k)^2 - res^2 against the remainder
    assign cand = (EW'(res_in) << (K + 1)) + (EW'(1) << (2 * K));
    assign rem_ext = EW'(rem_in);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_ext >= cand) begin
          rem_r[i] <= SQ_IN_W'(rem_ext - cand);
          res_r[i] <= res_in | (SQ_BITS'(1) << K);
        end else begin
          rem_r[i] <= rem_in;
          res_r[i] <= res_in;
        end
      end
    end
  end

  assign root_o = res_r[SQ_BITS-1];

endmodule

/* sv/qte_cordic.sv */
// pipelined vectoring cordic: atan2(y, x) rounded to q3.13 and clamped
module qte_cordic #(
  parameter int W = qte_pkg::RY_W,
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF,
  parameter int LIM = qte_pkg::PI_Q13
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] x_i,
  output logic signed [15:0]  angle_o
);
  import qte_pkg::*;

  logic signed [W-1:0]  x_r [STEPS+1];
  logic signed [W-1:0]  y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];
  logic                 zero_r [STEPS+1];

  // quarter-turn pre-rotation for the left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_r[0] <= y_i;
          y_r[0] <= -x_i;
          z_r[0] <= ZW'(HALF_PI_Q16);
        end else begin
          x_r[0] <= -y_i;
          y_r[0] <= x_i;
          z_r[0] <= -ZW'(HALF_PI_Q16);
        end
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  // micro-rotations, one per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = atan_q16(i);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ANG;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ANG;
        end
      end
    end
  end

  // round to q3.13 and clamp
  logic signed [ZW-1:0] z_rnd;
  logic signed [ZW-4:0] z_q13;
  logic signed [15:0]   angle_nxt;
  logic signed [15:0]   angle_r;

  assign z_rnd = z_r[STEPS] + ZW'(4);
  assign z_q13 = (ZW-3)'(z_rnd >>> 3);

  always_comb begin
    if (zero_r[STEPS]) begin
      angle_nxt = '0;
    end else if (z_q13 > LIM) begin
      angle_nxt = 16'(LIM);
    end else if (z_q13 < -LIM) begin
      angle_nxt = -16'(LIM);
    end else begin
      angle_nxt = 16'(z_q13);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

/* verif/quaternion_to_euler_angles_unit_tb.sv */
// testbench for the quaternion to euler angle unit: random and directed quaternions, scored
module quaternion_to_euler_angles_unit_tb;

  localparam int STEPS = qte_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = 2 + 2 + 29 + STEPS + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 750;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;
  logic out_pitch_clamped;

  quat_t  quat_q[$];
  euler_t angles_q[$];
  int     fail_count;
  int     idle_cycles;
  int     words_in;
  int     words_out;
  int     clamp_seen;
  bit     stim_done;

  quaternion_to_euler_angles_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_pitch_clamped(out_pitch_clamped)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // floor shift right
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // arctangent table at scale 2^16
  function automatic longint atan_step(int i);
    longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? t[i] : 0;
  endfunction

  // vectoring cordic, angle at scale 2^16
  function automatic longint vector_angle(longint ys, longint xs);
    longint xa, ya, za, tmp, dx, dy;
    xa = xs;
    ya = ys;
    za = 0;
    if (xa == 0 && ya == 0) return 0;
    if (xa < 0) begin
      if (ya >= 0) begin
        tmp = xa; xa = ya; ya = -tmp; za = qte_pkg::HALF_PI_Q16;
      end else begin
        tmp = xa; xa = -ya; ya = tmp; za = -qte_pkg::HALF_PI_Q16;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shr(ya, i);
      dy = floor_shr(xa, i);
      if (ya >= 0) begin
        xa += dx; ya -= dy; za += atan_step(i);
      end else begin
        xa -= dx; ya += dy; za -= atan_step(i);
      end
    end
    return za;
  endfunction

  // round 2^16 angle to q3.13 and saturate
  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = floor_shr(a + 4, 3);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // exact floor square root
  function automatic longint floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // expected angles for one quaternion
  function automatic euler_t euler_of(quat_t q);
    longint w, x, y, z, sr, cr, sp, sy, cy, one, p;
    logic [63:0] c2;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 <<< 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - x * z);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    e.roll = 16'(round_q13(vector_angle(sr, cr), qte_pkg::PI_Q13));
    e.yaw = 16'(round_q13(vector_angle(sy, cy), qte_pkg::PI_Q13));
    if (sp >= one || sp <= -one) begin
      p = (sp > 0) ? qte_pkg::HALF_PI_Q13 : -qte_pkg::HALF_PI_Q13;
      e.clamped = 1'b1;
    end else begin
      c2 = (64'd1 << 56) - 64'(sp * sp);
      p = round_q13(vector_angle(sp, floor_sqrt(c2)), qte_pkg::HALF_PI_Q13);
      e.clamped = 1'b0;
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // random quaternion with components up to about 0.71, occasional pitch at the gimbal edge, or corner values
  function automatic quat_t rand_quat();
    quat_t q;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      q.w = 16'(int'($urandom_range(0, 23170)) - 11585);
      q.x = 16'(int'($urandom_range(0, 23170)) - 11585);
      q.y = 16'(int'($urandom_range(0, 23170)) - 11585);
      q.z = 16'(int'($urandom_range(0, 23170)) - 11585);
    end else if (k < 8) begin
      q.w = 16'sd11585 + 16'(int'($urandom_range(0, 8)) - 4);
      q.y = (($urandom & 1) ? 16'sd11585 : -16'sd11585) + 16'(int'($urandom_range(0, 8)) - 4);
      q.x = 16'(int'($urandom_range(0, 40)) - 20);
      q.z = 16'(int'($urandom_range(0, 40)) - 20);
    end else begin
      q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
    end
    return q;
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s at word %0d: got %0d, expected %0d", field, words_out, got, want);
    fail_count++;
  endtask

  // stimulus
  initial begin
    quat_q.push_back(make_quat(16384, 0, 0, 0));
    quat_q.push_back(make_quat(0, 0, 0, 0));
    quat_q.push_back(make_quat(0, 16384, 0, 0));
    quat_q.push_back(make_quat(0, 0, 16384, 0));
    quat_q.push_back(make_quat(0, 0, 0, 16384));
    quat_q.push_back(make_quat(11585, 0, 11585, 0));
    quat_q.push_back(make_quat(11585, 0, -11585, 0));
    quat_q.push_back(make_quat(11586, 0, 11586, 0));
    quat_q.push_back(make_quat(11585, 11585, 0, 0));
    quat_q.push_back(make_quat(-32768, -32768, -32768, -32768));
    quat_q.push_back(make_quat(32767, 32767, 32767, 32767));
    quat_q.push_back(make_quat(-32768, 32767, -32768, 32767));
    quat_q.push_back(make_quat(-16384, 0, 0, 0));
    quat_q.push_back(make_quat(8192, 8192, 8192, 8192));
    quat_q.push_back(make_quat(8192, -8192, 8192, -8192));
    quat_q.push_back(make_quat(0, 11585, 11585, 0));
    quat_q.push_back(make_quat(0, 0, 11585, 11585));
    quat_q.push_back(make_quat(1, -1, 1, -1));
    quat_q.push_back(make_quat(16384, 16384, 16384, 16384));
    for (int i = 0; i < N_RANDOM; i++) quat_q.push_back(rand_quat());
  end

  // driver
  int gap;
  int pause_at;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap <= $urandom_range(0, 14);
      pause_at <= $urandom_range(100, 500);
    end else if (!in_valid || in_ready) begin
      if (in_valid) words_in++;
      if (words_in == pause_at && angles_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (gap != 0 && !(words_in < 40 || (words_in > 400 && words_in < 460))) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (quat_q.size() != 0) begin
        quat_t q;
        q = quat_q.pop_front();
        angles_q.push_back(euler_of(q));
        in_quat_w <= q.w; in_quat_x <= q.x; in_quat_y <= q.y; in_quat_z <= q.z;
        in_valid <= 1'b1;
        gap <= $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor and result stall
  int stall;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        euler_t e;
        int wait_n;
        if (angles_q.size() == 0) begin
          $display("unexpected result word");
          fail_count++;
        end else begin
          e = angles_q.pop_front();
          if (out_roll_angle !== e.roll)
            report_mismatch("roll", int'(out_roll_angle), int'(e.roll));
          if (out_pitch_angle !== e.pitch)
            report_mismatch("pitch", int'(out_pitch_angle), int'(e.pitch));
          if (out_yaw_angle !== e.yaw)
            report_mismatch("yaw", int'(out_yaw_angle), int'(e.yaw));
          if (out_pitch_clamped !== e.clamped)
            report_mismatch("pitch_clamped", int'(out_pitch_clamped), int'(e.clamped));
          if (e.clamped) clamp_seen++;
        end
        words_out++;
        // a draw of zero keeps taking words back to back
        wait_n = (words_out > 200 && words_out < 260) ? 0 : int'($urandom_range(0, 14));
        stall <= (wait_n > 0) ? wait_n - 1 : 0;
        out_ready <= (wait_n == 0);
      end else if (stall != 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", angles_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    fail_count = 0; words_in = 0; words_out = 0; clamp_seen = 0;
    idle_cycles = 0; stim_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && angles_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d quaternions, %0d results checked, %0d with pitch saturated",
             words_in, words_out, clamp_seen);
    if (fail_count == 0 && angles_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
